[rtl/mbps_pkg.sv]
// Shared types and constants for the masked byte pattern scanner.
`timescale 1ns / 1ps

package mbps_pkg;

  localparam int unsigned MaxPatternBytes = 32;
  localparam int unsigned PatternRegBytes = 32;
  localparam int unsigned CfgIndexWidth   = 3;
  localparam int unsigned CfgDataWidth    = 64;
  localparam int unsigned AddrWidth       = 64;
  localparam int unsigned LenWidth        = 6;

  typedef logic [7:0] byte_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_PATTERN_LENGTH = 3'd0,
    CFG_WILDCARD_MASK  = 3'd1,
    CFG_PATTERN_WORD_0 = 3'd2,
    CFG_PATTERN_WORD_1 = 3'd3,
    CFG_PATTERN_WORD_2 = 3'd4,
    CFG_PATTERN_WORD_3 = 3'd5,
    CFG_FIRST_ONLY     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [LenWidth-1:0]                pattern_length;
    logic [PatternRegBytes-1:0]         wildcard_mask;
    logic [PatternRegBytes-1:0][7:0]    pattern;
    logic                               first_only;
  } cfg_t;

endpackage

[rtl/mbps_cfg.sv]
// Configuration register file of the scanner.
`timescale 1ns / 1ps

module mbps_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wr_en_i,
  input  logic [mbps_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [mbps_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output mbps_pkg::cfg_t                      cfg_o
);

  mbps_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length <= mbps_pkg::LenWidth'(1);
      cfg_q.wildcard_mask  <= '0;
      cfg_q.pattern        <= '0;
      cfg_q.first_only     <= 1'b0;
    end else if (cfg_wr_en_i) begin
      case (cfg_index_i)
        mbps_pkg::CFG_PATTERN_LENGTH: begin
          cfg_q.pattern_length <= cfg_data_i[mbps_pkg::LenWidth-1:0];
        end
        mbps_pkg::CFG_WILDCARD_MASK: begin
          cfg_q.wildcard_mask <= cfg_data_i[mbps_pkg::PatternRegBytes-1:0];
        end
        mbps_pkg::CFG_PATTERN_WORD_0: begin
          cfg_q.pattern[0 +: 8] <= cfg_data_i;
        end
        mbps_pkg::CFG_PATTERN_WORD_1: begin
          cfg_q.pattern[8 +: 8] <= cfg_data_i;
        end
        mbps_pkg::CFG_PATTERN_WORD_2: begin
          cfg_q.pattern[16 +: 8] <= cfg_data_i;
        end
        mbps_pkg::CFG_PATTERN_WORD_3: begin
          cfg_q.pattern[24 +: 8] <= cfg_data_i;
        end
        mbps_pkg::CFG_FIRST_ONLY: begin
          cfg_q.first_only <= cfg_data_i[0];
        end
        default: begin
          // unknown index: ignore
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/mbps_window.sv]
// Byte window shift register and region fill counter.
`timescale 1ns / 1ps

module mbps_window #(
  parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::MaxPatternBytes,
  localparam int unsigned FW = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   advance_i,
  input  mbps_pkg::byte_t                        data_i,
  input  logic                                   region_i,
  output logic [MAX_PATTERN_BYTES-1:0][7:0]      win_next_o,
  output logic [FW-1:0]                          fill_next_o
);

  logic [MAX_PATTERN_BYTES-1:0][7:0] win_q;
  logic [FW-1:0]                     fill_q;
  logic [FW-1:0]                     fill_d;

  // Entry k holds the byte taken k items ago; stale entries are masked by the fill count.
  always_comb begin
    win_next_o[0] = data_i;
    for (int unsigned j = 1; j < MAX_PATTERN_BYTES; j++) begin
      win_next_o[j] = win_q[j-1];
    end
  end

  always_comb begin
    if (region_i) begin
      fill_d = FW'(1);
    end else if (fill_q == FW'(MAX_PATTERN_BYTES)) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + FW'(1);
    end
  end

  assign fill_next_o = fill_d;

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      win_q <= win_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (advance_i) begin
      fill_q <= fill_d;
    end
  end

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MAX_PATTERN_BYTES))
    else $error("fill count above window depth");

endmodule

[rtl/mbps_match.sv]
// Parallel masked compare of the window against the pattern.
`timescale 1ns / 1ps

module mbps_match #(
  parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::MaxPatternBytes,
  localparam int unsigned FW = $clog2(MAX_PATTERN_BYTES + 1),
  localparam int unsigned IW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1
) (
  input  mbps_pkg::cfg_t                      cfg_i,
  input  logic [MAX_PATTERN_BYTES-1:0][7:0]   win_i,
  input  logic [FW-1:0]                       fill_i,
  input  logic [mbps_pkg::AddrWidth-1:0]      addr_i,
  output logic                                hit_o,
  output logic [mbps_pkg::AddrWidth-1:0]      match_addr_o
);

  logic [FW-1:0]                len_eff;
  logic [MAX_PATTERN_BYTES-1:0] pos_ok;

  // Clamp an overlong length to the window depth.
  always_comb begin
    if ({1'b0, cfg_i.pattern_length} > 7'(MAX_PATTERN_BYTES)) begin
      len_eff = FW'(MAX_PATTERN_BYTES);
    end else begin
      len_eff = FW'(cfg_i.pattern_length);
    end
  end

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_pos
    logic [FW-1:0]   idx_full;
    mbps_pkg::byte_t win_byte;
    mbps_pkg::byte_t pat_byte;
    logic            wild;

    // Pattern byte k arrived len-1-k items ago.
    assign idx_full = len_eff - FW'(1) - FW'(k);
    assign win_byte = win_i[idx_full[IW-1:0]];

    if (k < mbps_pkg::PatternRegBytes) begin : g_cfg
      assign pat_byte = cfg_i.pattern[k];
      assign wild     = cfg_i.wildcard_mask[k];
    end else begin : g_zero
      assign pat_byte = '0;
      assign wild     = 1'b0;
    end

    assign pos_ok[k] = (FW'(k) >= len_eff) || wild || (win_byte == pat_byte);
  end

  assign hit_o = (len_eff != '0) && (fill_i >= len_eff) && (&pos_ok);
  assign match_addr_o = addr_i - mbps_pkg::AddrWidth'(len_eff) + mbps_pkg::AddrWidth'(1);

endmodule

[rtl/masked_byte_pattern_scanner.sv]
// Top level of the masked byte pattern scanner.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------
//  input   | in        | in_valid_i / in_stall_o    | data_byte_i, byte_address_i,
//          |           |                            | region_start_i, scan_start_i
//  result  | out       | out_valid_o / out_stall_i  | match_found_o, match_address_o
//  config  | in        | cfg_wr_en_i                | cfg_index_i, cfg_data_i
//
// One item per cycle unless out_stall_i holds the result; an item is taken into the input
// register, and its result is then captured in the result register, the two registers
// around the window compare.
// Reset clears the fill count, the found flag and both valid flags; configuration
// returns to length one, no wildcards, zero pattern, all matches reported.
// A stalled result holds the result register; the input register still takes one more
// item, and in_stall_o rises only when both registers are full.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner #(
  parameter int unsigned MAX_PATTERN_BYTES = mbps_pkg::MaxPatternBytes
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wr_en_i,
  input  logic [mbps_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [mbps_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          data_byte_i,
  input  logic [mbps_pkg::AddrWidth-1:0]      byte_address_i,
  input  logic                                region_start_i,
  input  logic                                scan_start_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                match_found_o,
  output logic [mbps_pkg::AddrWidth-1:0]      match_address_o
);

  localparam int unsigned FW = $clog2(MAX_PATTERN_BYTES + 1);

  mbps_pkg::cfg_t cfg;

  logic                              s1_valid_q;
  logic                              s1_valid_d;
  mbps_pkg::byte_t                   s1_data_q;
  logic [mbps_pkg::AddrWidth-1:0]    s1_addr_q;
  logic                              s1_region_q;
  logic                              s1_scan_q;

  logic                              out_valid_q;
  logic                              match_found_q;
  logic [mbps_pkg::AddrWidth-1:0]    match_address_q;

  logic                              found_q;
  logic                              found_d;

  logic                              in_accept;
  logic                              out_ready;
  logic                              s1_adv;

  logic [MAX_PATTERN_BYTES-1:0][7:0] win_next;
  logic [FW-1:0]                     fill_next;
  logic                              hit_raw;
  logic                              report;
  logic [mbps_pkg::AddrWidth-1:0]    hit_addr;

  mbps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_en_i (cfg_wr_en_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_data_q   <= data_byte_i;
      s1_addr_q   <= byte_address_i;
      s1_region_q <= region_start_i;
      s1_scan_q   <= scan_start_i;
    end
  end

  mbps_window #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (s1_adv),
    .data_i      (s1_data_q),
    .region_i    (s1_region_q),
    .win_next_o  (win_next),
    .fill_next_o (fill_next)
  );

  mbps_match #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_match (
    .cfg_i        (cfg),
    .win_i        (win_next),
    .fill_i       (fill_next),
    .addr_i       (s1_addr_q),
    .hit_o        (hit_raw),
    .match_addr_o (hit_addr)
  );

  // Drop repeat matches in first-only mode until the next scan.
  assign found_d = s1_scan_q ? 1'b0 : found_q;
  assign report  = hit_raw && !(cfg.first_only && found_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (s1_adv) begin
      found_q <= found_d || report;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      match_found_q   <= report;
      match_address_q <= report ? hit_addr : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign match_found_o   = match_found_q;
  assign match_address_o = match_address_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free register");

  a_report_sets_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && report) |=> found_q)
    else $error("reported match did not set the found flag");

  a_no_match_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !match_found_q) |-> (match_address_q == '0))
    else $error("non-match result carries an address");

endmodule

[test/mbps_scan_checker.sv]
// Result predictor and comparator for the masked byte pattern scanner.
`timescale 1ns / 1ps

module mbps_scan_checker import mbps_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_wr_en_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  byte_t                    data_byte_i,
  input  logic [AddrWidth-1:0]     byte_address_i,
  input  logic                     region_start_i,
  input  logic                     scan_start_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic                     match_found_i,
  input  logic [AddrWidth-1:0]     match_address_i,
  output int unsigned              mismatch_count_o,
  output int unsigned              matches_pending_o,
  output int unsigned              hits_reported_o
);

  typedef struct packed {
    logic                 found;
    logic [AddrWidth-1:0] addr;
  } match_t;

  match_t               expected_matches[$];
  byte_t                recent_bytes[MaxPatternBytes];
  int unsigned          region_fill;
  logic                 scan_hit;
  logic [LenWidth-1:0]  len_q;
  logic [31:0]          wild_q;
  logic [3:0][63:0]     pattern_q;
  logic                 first_only_q;

  function automatic match_t next_match(input byte_t data, input logic [AddrWidth-1:0] addr,
                                        input logic region, input logic scan);
    match_t      res;
    int unsigned span;
    int unsigned k;
    logic        hit;
    res = '0;
    if (region) begin
      for (k = 0; k < MaxPatternBytes; k++) recent_bytes[k] = '0;
      region_fill = 0;
    end
    if (scan) scan_hit = 1'b0;
    for (k = MaxPatternBytes - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
    recent_bytes[0] = data;
    if (region_fill < MaxPatternBytes) region_fill++;
    span = (len_q > MaxPatternBytes) ? MaxPatternBytes : len_q;
    hit = (span != 0) && (region_fill >= span);
    for (k = 0; k < span; k++) begin
      // pattern byte k arrived span-1-k items ago
      if (!wild_q[k] && recent_bytes[span - 1 - k] != pattern_q[k / 8][(k % 8) * 8 +: 8]) begin
        hit = 1'b0;
      end
    end
    // drop repeat hits within a scan in first-only mode
    if (hit && first_only_q && scan_hit) hit = 1'b0;
    if (hit) begin
      scan_hit  = 1'b1;
      res.found = 1'b1;
      res.addr  = addr - AddrWidth'(span - 1);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    match_t want;
    if (!rst_ni) begin
      expected_matches.delete();
      for (int k = 0; k < MaxPatternBytes; k++) recent_bytes[k] = '0;
      region_fill      = 0;
      scan_hit         = 1'b0;
      len_q            = LenWidth'(1);
      wild_q           = '0;
      pattern_q        = '0;
      first_only_q     = 1'b0;
      mismatch_count_o = 0;
      hits_reported_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (match_found_i === 1'b1) hits_reported_o++;
        if (expected_matches.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: unexpected result, expected none, got found %0b address %h",
                   $time, match_found_i, match_address_i);
        end else begin
          want = expected_matches.pop_front();
          if (match_found_i !== want.found) begin
            mismatch_count_o++;
            $display("%0t: match_found expected %0b got %0b",
                     $time, want.found, match_found_i);
          end
          if (match_address_i !== want.addr) begin
            mismatch_count_o++;
            $display("%0t: match_address expected %h got %h",
                     $time, want.addr, match_address_i);
          end
        end
      end
      if (cfg_wr_en_i) begin
        case (cfg_index_i)
          CFG_PATTERN_LENGTH: len_q        = cfg_data_i[LenWidth-1:0];
          CFG_WILDCARD_MASK:  wild_q       = cfg_data_i[31:0];
          CFG_PATTERN_WORD_0: pattern_q[0] = cfg_data_i;
          CFG_PATTERN_WORD_1: pattern_q[1] = cfg_data_i;
          CFG_PATTERN_WORD_2: pattern_q[2] = cfg_data_i;
          CFG_PATTERN_WORD_3: pattern_q[3] = cfg_data_i;
          CFG_FIRST_ONLY:     first_only_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_matches.push_back(next_match(data_byte_i, byte_address_i,
                                              region_start_i, scan_start_i));
      end
    end
    matches_pending_o = expected_matches.size();
  end

endmodule

[test/tb_masked_byte_pattern_scanner.sv]
// Stimulus, clocking and verdict for the masked byte pattern scanner.
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scanner;
  import mbps_pkg::*;

  localparam int unsigned RandomItems   = 500;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned DrainCycles   = 4;
  localparam logic [CfgIndexWidth-1:0] CfgUnusedIdx = 3'd7;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_wr_en_i;
  logic [CfgIndexWidth-1:0] cfg_index_i;
  logic [CfgDataWidth-1:0]  cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  byte_t                    data_byte_i;
  logic [AddrWidth-1:0]     byte_address_i;
  logic                     region_start_i;
  logic                     scan_start_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     match_found_o;
  logic [AddrWidth-1:0]     match_address_o;

  int unsigned mismatch_count;
  int unsigned matches_pending;
  int unsigned hits_reported;

  // mirror of the programmed pattern, used to build signatures
  logic [LenWidth-1:0]  cur_len;
  logic [31:0]          cur_wild;
  logic [3:0][63:0]     cur_words;
  logic [AddrWidth-1:0] next_addr;
  int unsigned          items_sent;
  int unsigned          setting_count;
  int unsigned          hold_offs;
  int unsigned          cycle_count;
  logic                 src_gaps_on;
  logic                 sink_stalls_on;
  logic                 hold_off_req;

  masked_byte_pattern_scanner u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .byte_address_i  (byte_address_i),
    .region_start_i  (region_start_i),
    .scan_start_i    (scan_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .match_found_o   (match_found_o),
    .match_address_o (match_address_o)
  );

  mbps_scan_checker u_scan_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .byte_address_i    (byte_address_i),
    .region_start_i    (region_start_i),
    .scan_start_i      (scan_start_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .match_found_i     (match_found_o),
    .match_address_i   (match_address_o),
    .mismatch_count_o  (mismatch_count),
    .matches_pending_o (matches_pending),
    .hits_reported_o   (hits_reported)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [AddrWidth-1:0] fresh_address();
    case ($urandom_range(0, 3))
      0: return 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 15));
      1: return 64'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [63:0] value);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_pattern(input logic [LenWidth-1:0] len, input logic [31:0] wild,
                              input logic [3:0][63:0] words, input logic first_only);
    write_reg(CFG_PATTERN_LENGTH, 64'(len));
    write_reg(CFG_WILDCARD_MASK, 64'(wild));
    write_reg(CFG_PATTERN_WORD_0, words[0]);
    write_reg(CFG_PATTERN_WORD_1, words[1]);
    write_reg(CFG_PATTERN_WORD_2, words[2]);
    write_reg(CFG_PATTERN_WORD_3, words[3]);
    write_reg(CFG_FIRST_ONLY, 64'(first_only));
    cur_len   = len;
    cur_wild  = wild;
    cur_words = words;
  endtask

  task automatic send_byte(input byte_t data, input logic region, input logic scan);
    int unsigned gap;
    gap = src_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= data;
    byte_address_i <= next_addr;
    region_start_i <= region;
    scan_start_i   <= scan;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    next_addr = next_addr + 64'd1;
    items_sent++;
  endtask

  task automatic random_byte(input byte_t data);
    logic region;
    logic scan;
    region = ($urandom_range(0, 99) < 4);
    scan   = ($urandom_range(0, 99) < 5);
    if (region) next_addr = fresh_address();
    send_byte(data, region, scan);
    if (items_sent % 200 == 100) hold_off_req = 1'b1;
  endtask

  // noise prefix, then the pattern with random wildcard bytes, sometimes with one byte spoilt
  task automatic send_signature();
    int unsigned span;
    int unsigned prefix;
    int unsigned bad;
    int unsigned k;
    logic        spoil;
    byte_t       b;
    span   = (cur_len > MaxPatternBytes) ? MaxPatternBytes : cur_len;
    prefix = $urandom_range(0, 3);
    spoil  = ($urandom_range(0, 3) == 0);
    bad    = (span != 0) ? $urandom_range(0, span - 1) : 0;
    for (k = 0; k < prefix; k++) random_byte(byte_t'($urandom));
    for (k = 0; k < span; k++) begin
      b = cur_wild[k] ? byte_t'($urandom) : cur_words[k / 8][(k % 8) * 8 +: 8];
      if (spoil && k == bad) b = b ^ byte_t'($urandom_range(1, 255));
      random_byte(b);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (matches_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned hold;
    out_stall_i    = 1'b0;
    sink_stalls_on = 1'b1;
    hold_offs      = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold         = HoldOffCycles;
        hold_off_req = 1'b0;
        hold_offs++;
      end else begin
        hold = sink_stalls_on ? $urandom_range(0, 6) : 0;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
      if ($urandom_range(0, 31) == 0) sink_stalls_on = !sink_stalls_on;
    end
  end

  initial begin : stimulus
    logic [LenWidth-1:0] len;
    logic [31:0]         wild;
    logic [3:0][63:0]    words;
    int unsigned         random_start;
    int unsigned         phase_end;
    int unsigned         w;
    rst_ni         = 1'b0;
    cfg_wr_en_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    data_byte_i    = '0;
    byte_address_i = '0;
    region_start_i = 1'b0;
    scan_start_i   = 1'b0;
    hold_off_req   = 1'b0;
    src_gaps_on    = 1'b1;
    next_addr      = '0;
    items_sent     = 0;
    setting_count  = 0;
    cur_len        = LenWidth'(1);
    cur_wild       = '0;
    cur_words      = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: length one, zero pattern
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b0, 1'b0);
    wait_drained();

    // unknown index must leave everything alone
    write_reg(CfgUnusedIdx, '1);
    words    = '0;
    words[0] = 64'h0000_0000_EFBE_ADDE;
    load_pattern(LenWidth'(4), 32'h0000_0004, words, 1'b1);
    // match straddling the address wrap
    next_addr = 64'hFFFF_FFFF_FFFF_FFFE;
    send_byte(8'hDE, 1'b1, 1'b1);
    send_byte(8'hAD, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'hEF, 1'b0, 1'b0);
    // second hit in the same scan is suppressed
    send_byte(8'hDE, 1'b0, 1'b0);
    send_byte(8'hAD, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hEF, 1'b0, 1'b0);
    // new scan on the final byte reopens reporting
    send_byte(8'hDE, 1'b0, 1'b0);
    send_byte(8'hAD, 1'b0, 1'b0);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'hEF, 1'b0, 1'b1);
    // region break inside the pattern
    send_byte(8'hDE, 1'b0, 1'b1);
    send_byte(8'hAD, 1'b0, 1'b0);
    next_addr = 64'h0000_1000_0000_0000;
    send_byte(8'hBE, 1'b1, 1'b0);
    send_byte(8'hEF, 1'b0, 1'b0);
    wait_drained();

    // zero length never matches
    load_pattern('0, '0, '0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    wait_drained();

    // overlong length clamps to the full window; short fill gives no match
    load_pattern('1, '1, '1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    wait_drained();
    setting_count = 4;

    random_start = items_sent;
    while (items_sent < random_start + RandomItems) begin
      case ($urandom_range(0, 9))
        0: len = LenWidth'(32);
        1: len = LenWidth'($urandom_range(33, 63));
        2: len = '0;
        3: len = LenWidth'(1);
        default: len = LenWidth'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 4))
        0: wild = '0;
        1: wild = '1;
        default: wild = $urandom & $urandom & $urandom;
      endcase
      for (w = 0; w < 4; w++) begin
        case ($urandom_range(0, 5))
          0: words[w] = '0;
          1: words[w] = '1;
          default: words[w] = {$urandom, $urandom};
        endcase
      end
      load_pattern(len, wild, words, 1'($urandom_range(0, 1)));
      setting_count++;
      src_gaps_on = ($urandom_range(0, 3) != 0);
      next_addr   = fresh_address();
      send_byte(byte_t'($urandom), 1'b1, 1'($urandom_range(0, 1)));
      phase_end = items_sent + $urandom_range(30, 80);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) < 7) send_signature();
        else random_byte(byte_t'($urandom));
      end
      wait_drained();
    end

    repeat (8) @(negedge clk_i);
    $display("Scanned %0d bytes under %0d pattern settings; %0d matches reported",
             items_sent, setting_count, hits_reported);
    $display("Receiver held off %0d times to back up the input", hold_offs);
    if (mismatch_count == 0 && matches_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
